// File: sv/plic_pkg.sv
package plic_pkg;

   // Controller sizing.
   localparam int NUM_SOURCES  = 64;
   localparam int MAX_PRIORITY = 7;
   localparam int PRIO_W       = $clog2(MAX_PRIORITY + 1);
   localparam int SRC_W        = $clog2(NUM_SOURCES);
   localparam int CNT_W        = $clog2(NUM_SOURCES + 1);
   localparam int BITMAP_WORDS = (NUM_SOURCES + 31) / 32;
   localparam int WORD_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

   // Port widths.
   localparam int OP_W      = 2;
   localparam int ADDR_W    = 26;
   localparam int DATA_W    = 32;
   localparam int REQ_SRC_W = 6;

   // Priority slots occupy the window below the pending block.
   localparam int SLOT_W = 10;

   // Register map.
   localparam logic [ADDR_W-1:0] PENDING_BASE   = 26'h000_1000;
   localparam logic [ADDR_W-1:0] ENABLE_BASE    = 26'h000_2000;
   localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = 26'h020_0000;
   localparam logic [ADDR_W-1:0] CLAIM_ADDR     = 26'h020_0004;
   localparam logic [ADDR_W-1:0] BITMAP_SPAN    = ADDR_W'(4 * BITMAP_WORDS);

   // Operation codes of a request.
   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RAISE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDWAIT,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Control from the sequencer to the arbitration unit.
   typedef struct packed {
      logic init;
      logic step;
      logic eligible;
   } scan_ctl_type;

   // Saturate a written level at the maximum priority.
   function automatic logic [PRIO_W-1:0] clamp_level(input logic [DATA_W-1:0] v);
      logic [PRIO_W-1:0] r;
      if (v > DATA_W'(MAX_PRIORITY)) begin
         r = PRIO_W'(MAX_PRIORITY);
      end else begin
         r = v[PRIO_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: sv/platform_interrupt_controller_top.sv
// Single-context platform interrupt controller.
// Request channel: a transaction is taken at a rising edge where start is high
// and busy is low. req_operation selects a bus read, a bus write or a source
// raising its interrupt; req_address, req_write_data and req_source carry the rest.
// Response channel: every request gives exactly one response, shown for one
// cycle with rsp_strobe high. rsp_read_data holds read data or the claimed id,
// rsp_irq_request tells whether an eligible source remains after the request,
// and rsp_bad_access flags an address that decodes to no register.
// Sequence: ST_EXEC executes the request, a priority read passes through
// ST_RDWAIT, and ST_SCAN rescans every source before ST_RESP gives the strobe.
// Busy stays high throughout, and the next request may be taken on the cycle
// after the strobe. In the arbitration scan, after every request, one compare
// unit walks all sources through the single read port of the priority memory.
// A claim answers from the winner of the previous scan.
// Reset clears all priorities, bitmaps and the threshold at once; no clearing
// pass is needed. The receiver cannot stall, so a response is never held.
module platform_interrupt_controller_top
   import plic_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [DATA_W-1:0]    req_write_data,
   input  logic [REQ_SRC_W-1:0] req_source,
   output logic                 rsp_strobe,
   output logic [DATA_W-1:0]    rsp_read_data,
   output logic                 rsp_irq_request,
   output logic                 rsp_bad_access
);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [NUM_SOURCES-1:0] pending_ff, pending_in;
   logic [NUM_SOURCES-1:0] enable_ff, enable_in;
   logic [NUM_SOURCES-1:0] in_service_ff, in_service_in;
   logic [PRIO_W-1:0]      threshold_ff, threshold_in;
   logic [DATA_W-1:0]      rdata_ff, rdata_in;
   logic                   bad_ff, bad_in;

   // Captured request.
   logic [OP_W-1:0]        op_ff, op_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [DATA_W-1:0]      wdata_ff, wdata_in;
   logic [REQ_SRC_W-1:0]   src_ff, src_in;

   logic                   mem_wr_en;
   logic [SRC_W-1:0]       mem_rd_addr;
   logic [PRIO_W-1:0]      mem_rd_data;
   scan_ctl_type           scan_ctl;
   logic [SRC_W-1:0]       scan_idx;
   logic [SRC_W-1:0]       best;

   logic [SLOT_W-1:0]      slot;
   logic [WORD_W-1:0]      word_sel;
   logic [SRC_W-1:0]       raise_idx;
   logic [SRC_W-1:0]       done_idx;
   logic [DATA_W-1:0]      pending_word;
   logic [DATA_W-1:0]      enable_word;

   // Address fields of the captured request.
   assign slot      = addr_ff[SLOT_W+1:2];
   assign word_sel  = addr_ff[WORD_W+1:2];
   assign raise_idx = SRC_W'(src_ff);
   assign done_idx  = SRC_W'(wdata_ff);
   assign scan_idx  = SRC_W'(scan_cnt_ff - 1'b1);

   // Bitmap words seen by the bus; source zero always reads as clear.
   always_comb begin
      pending_word = '0;
      enable_word  = '0;
      for (int k = 0; k < BITMAP_WORDS; k++) begin
         if (word_sel == WORD_W'(k)) begin
            for (int b = 0; b < 32; b++) begin
               if ((k * 32 + b != 0) && (k * 32 + b < NUM_SOURCES)) begin
                  pending_word[b] = pending_ff[k * 32 + b];
                  enable_word[b]  = enable_ff[k * 32 + b];
               end
            end
         end
      end
   end

   // Sequencer: execute the transaction, then rescan every source.
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      pending_in    = pending_ff;
      enable_in     = enable_ff;
      in_service_in = in_service_ff;
      threshold_in  = threshold_ff;
      rdata_in      = rdata_ff;
      bad_in        = bad_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      wdata_in      = wdata_ff;
      src_in        = src_ff;
      mem_wr_en     = 1'b0;
      mem_rd_addr   = SRC_W'(scan_cnt_ff);
      scan_ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               addr_in  = req_address;
               wdata_in = req_write_data;
               src_in   = req_source;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            rdata_in    = '0;
            bad_in      = 1'b0;
            mem_rd_addr = SRC_W'(slot);
            state_in    = ST_SCAN;
            case (op_type'(op_ff))
               OP_RAISE: begin
                  // A source already in service keeps its raise held off.
                  if ((src_ff != '0) && (32'(src_ff) < NUM_SOURCES) &&
                      !in_service_ff[raise_idx]) begin
                     pending_in[raise_idx] = 1'b1;
                  end
               end
               OP_READ, OP_WRITE: begin
                  if (addr_ff[1:0] != 2'b00) begin
                     bad_in = 1'b1;
                  end else if (addr_ff < PENDING_BASE) begin
                     // Priority slot of one source.
                     if (32'(slot) >= NUM_SOURCES) begin
                        bad_in = 1'b1;
                     end else if (op_ff == OP_WRITE) begin
                        mem_wr_en = (slot != '0);
                     end else begin
                        state_in = ST_RDWAIT;
                     end
                  end else if ((addr_ff >= PENDING_BASE) &&
                               (addr_ff < PENDING_BASE + BITMAP_SPAN)) begin
                     // The pending bitmap is read-only.
                     if (op_ff == OP_READ) begin
                        rdata_in = pending_word;
                     end
                  end else if ((addr_ff >= ENABLE_BASE) &&
                               (addr_ff < ENABLE_BASE + BITMAP_SPAN)) begin
                     if (op_ff == OP_WRITE) begin
                        for (int k = 0; k < BITMAP_WORDS; k++) begin
                           if (word_sel == WORD_W'(k)) begin
                              for (int b = 0; b < 32; b++) begin
                                 if ((k * 32 + b != 0) && (k * 32 + b < NUM_SOURCES)) begin
                                    enable_in[k * 32 + b] = wdata_ff[b];
                                 end
                              end
                           end
                        end
                     end else begin
                        rdata_in = enable_word;
                     end
                  end else if (addr_ff == THRESHOLD_ADDR) begin
                     if (op_ff == OP_WRITE) begin
                        threshold_in = clamp_level(wdata_ff);
                     end else begin
                        rdata_in = DATA_W'(threshold_ff);
                     end
                  end else if (addr_ff == CLAIM_ADDR) begin
                     if (op_ff == OP_WRITE) begin
                        // Complete: only a real source id is honored.
                        if ((wdata_ff != '0) && (wdata_ff < DATA_W'(NUM_SOURCES))) begin
                           in_service_in[done_idx] = 1'b0;
                        end
                     end else begin
                        // Claim: the winner of the last scan is still current.
                        if (best != '0) begin
                           pending_in[best]    = 1'b0;
                           in_service_in[best] = 1'b1;
                        end
                        rdata_in = DATA_W'(best);
                     end
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_RDWAIT: begin
            rdata_in = DATA_W'(mem_rd_data);
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            // Count n issues the read of source n and compares source n - 1.
            scan_ctl.init     = (scan_cnt_ff == '0);
            scan_ctl.step     = (scan_cnt_ff != '0);
            scan_ctl.eligible = pending_ff[scan_idx] & enable_ff[scan_idx];
            if (scan_cnt_ff == CNT_W'(NUM_SOURCES)) begin
               scan_cnt_in = '0;
               state_in    = ST_RESP;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end

         ST_RESP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_cnt_ff   <= '0;
         pending_ff    <= '0;
         enable_ff     <= '0;
         in_service_ff <= '0;
         threshold_ff  <= '0;
         rdata_ff      <= '0;
         bad_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         pending_ff    <= pending_in;
         enable_ff     <= enable_in;
         in_service_ff <= in_service_in;
         threshold_ff  <= threshold_in;
         rdata_ff      <= rdata_in;
         bad_ff        <= bad_in;
      end
   end

   // Captured request payload.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      src_ff   <= src_in;
   end

   plic_prio_mem u_prio_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (SRC_W'(slot)),
      .wr_data (clamp_level(wdata_ff)),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   plic_arbiter u_arbiter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .idx       (scan_idx),
      .prio      (mem_rd_data),
      .threshold (threshold_ff),
      .best      (best)
   );

   // Response ports.
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_RESP);
   assign rsp_read_data   = rdata_ff;
   assign rsp_irq_request = (best != '0);
   assign rsp_bad_access  = bad_ff;

   // A source is never pending and in service at once.
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff & in_service_ff) == '0)
      else $error("source both pending and in service");

   // A reported request comes from a source that is pending and enabled.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_irq_request) |-> (pending_ff[best] && enable_ff[best]))
      else $error("interrupt request from an ineligible source");

   // Each transaction gives a single one-cycle strobe and then frees the port.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("response strobe not followed by idle");

   // The scan always completes before a response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(scan_cnt_ff) == CNT_W'(NUM_SOURCES)))
      else $error("response before the scan finished");

endmodule

// File: sv/plic_prio_mem.sv
module plic_prio_mem
   import plic_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [SRC_W-1:0]  wr_addr,
   input  logic [PRIO_W-1:0] wr_data,
   input  logic [SRC_W-1:0]  rd_addr,
   output logic [PRIO_W-1:0] rd_data
);

   logic [PRIO_W-1:0]      mem [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] valid_ff;
   logic [PRIO_W-1:0]      rd_data_ff;

   // An entry never written since reset reads as priority zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/plic_arbiter.sv
module plic_arbiter
   import plic_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  logic [SRC_W-1:0]  idx,
   input  logic [PRIO_W-1:0] prio,
   input  logic [PRIO_W-1:0] threshold,
   output logic [SRC_W-1:0]  best
);

   logic [SRC_W-1:0]  best_ff, best_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;

   // One compare per cycle; a strictly higher level wins, so ties keep the lower id.
   always_comb begin
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      if (ctl.init) begin
         best_in      = '0;
         best_prio_in = threshold;
      end else if (ctl.step && ctl.eligible && (prio > best_prio_ff)) begin
         best_in      = idx;
         best_prio_in = prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         best_prio_ff <= '0;
      end else begin
         best_ff      <= best_in;
         best_prio_ff <= best_prio_in;
      end
   end

   assign best = best_ff;

endmodule

// File: test/tb_platform_interrupt_controller_top.sv
module tb_platform_interrupt_controller_top
   import plic_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF      = 4;
   localparam int RSP_LATENCY   = NUM_SOURCES + 4;
   localparam int RANDOM_PER_PH = 150;
   localparam int LIMIT_CYCLES  = 400_000;
   localparam int MAX_PRINTED   = 60;

   // One request transaction and the response it is expected to produce.
   typedef struct packed {
      op_type                 op;
      logic [ADDR_W-1:0]      addr;
      logic [DATA_W-1:0]      wdata;
      logic [REQ_SRC_W-1:0]   src;
   } plic_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic              irq;
      logic              bad;
   } plic_rsp_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 start           = 1'b0;
   logic [OP_W-1:0]      req_operation   = '0;
   logic [ADDR_W-1:0]    req_address     = '0;
   logic [DATA_W-1:0]    req_write_data  = '0;
   logic [REQ_SRC_W-1:0] req_source      = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic [DATA_W-1:0]    rsp_read_data;
   logic                 rsp_irq_request;
   logic                 rsp_bad_access;

   // Queues between the stimulus, the driver and the monitor.
   plic_req_type req_q[$];
   plic_rsp_type due_rsp_q[$];
   plic_req_type held_req;

   // Shadow copy of the controller state.
   logic [PRIO_W-1:0]      shadow_prio[NUM_SOURCES];
   logic [NUM_SOURCES-1:0] shadow_pend = '0;
   logic [NUM_SOURCES-1:0] shadow_enab = '0;
   logic [NUM_SOURCES-1:0] shadow_insvc = '0;
   logic [PRIO_W-1:0]      shadow_thresh = '0;

   int sender_idle_pct = 0;
   int err_cnt         = 0;
   int cycle_cnt       = 0;
   int accepted_cnt    = 0;
   int checked_cnt     = 0;
   int claims_granted  = 0;
   int bad_predicted   = 0;
   int irq_seen        = 0;

   platform_interrupt_controller_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_source      (req_source),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_request (rsp_irq_request),
      .rsp_bad_access  (rsp_bad_access)
   );

   always #CLK_HALF clock = ~clock;

   // Saturate a written value at the top priority level.
   function automatic logic [PRIO_W-1:0] sat_level(logic [DATA_W-1:0] v);
      if (v > DATA_W'(MAX_PRIORITY)) begin
         return PRIO_W'(MAX_PRIORITY);
      end
      return v[PRIO_W-1:0];
   endfunction

   // Highest-priority enabled pending source above the threshold, lowest id on ties.
   function automatic int select_winner();
      int best;
      int best_level;
      best       = 0;
      best_level = int'(shadow_thresh);
      for (int s = 1; s < NUM_SOURCES; s++) begin
         if (shadow_pend[s] && shadow_enab[s] && int'(shadow_prio[s]) > best_level) begin
            best       = s;
            best_level = int'(shadow_prio[s]);
         end
      end
      return best;
   endfunction

   // One 32-bit word of a source bitmap; source zero always reads as zero.
   function automatic logic [DATA_W-1:0] bitmap_word(logic [NUM_SOURCES-1:0] bits, int w);
      logic [DATA_W-1:0] word;
      int s;
      word = '0;
      for (int b = 0; b < 32; b++) begin
         s = w * 32 + b;
         if (s != 0 && s < NUM_SOURCES) begin
            word[b] = bits[s];
         end
      end
      return word;
   endfunction

   // Apply one transaction to the shadow state and return the response it yields.
   function automatic plic_rsp_type compute_response(plic_req_type r);
      plic_rsp_type o;
      int        s;
      int        w;
      bit        wr;
      o  = '0;
      wr = (r.op == OP_WRITE);
      if (r.op == OP_RAISE) begin
         // A raise is held off while the source is in service.
         if (r.src != 0 && int'(r.src) < NUM_SOURCES && !shadow_insvc[r.src]) begin
            shadow_pend[r.src] = 1'b1;
         end
      end else if (r.op == OP_READ || r.op == OP_WRITE) begin
         if (r.addr[1:0] != 2'b00) begin
            o.bad = 1'b1;
         end else if (r.addr < PENDING_BASE) begin
            s = int'(r.addr >> 2);
            if (s >= NUM_SOURCES) begin
               o.bad = 1'b1;
            end else if (wr) begin
               if (s != 0) begin
                  shadow_prio[s] = sat_level(r.wdata);
               end
            end else if (s != 0) begin
               o.rdata = DATA_W'(shadow_prio[s]);
            end
         end else if (r.addr < PENDING_BASE + BITMAP_SPAN) begin
            // The pending bitmap is read-only; a write is silently dropped.
            if (!wr) begin
               o.rdata = bitmap_word(shadow_pend, int'((r.addr - PENDING_BASE) >> 2));
            end
         end else if (r.addr >= ENABLE_BASE && r.addr < ENABLE_BASE + BITMAP_SPAN) begin
            w = int'((r.addr - ENABLE_BASE) >> 2);
            if (wr) begin
               for (int b = 0; b < 32; b++) begin
                  s = w * 32 + b;
                  if (s != 0 && s < NUM_SOURCES) begin
                     shadow_enab[s] = r.wdata[b];
                  end
               end
            end else begin
               o.rdata = bitmap_word(shadow_enab, w);
            end
         end else if (r.addr == THRESHOLD_ADDR) begin
            if (wr) begin
               shadow_thresh = sat_level(r.wdata);
            end else begin
               o.rdata = DATA_W'(shadow_thresh);
            end
         end else if (r.addr == CLAIM_ADDR) begin
            if (wr) begin
               if (r.wdata != 0 && r.wdata < DATA_W'(NUM_SOURCES)) begin
                  shadow_insvc[r.wdata[SRC_W-1:0]] = 1'b0;
               end
            end else begin
               s = select_winner();
               if (s != 0) begin
                  shadow_pend[s]  = 1'b0;
                  shadow_insvc[s] = 1'b1;
                  claims_granted++;
               end
               o.rdata = DATA_W'(s);
            end
         end else begin
            o.bad = 1'b1;
         end
      end
      o.irq = (select_winner() != 0);
      if (o.bad) begin
         bad_predicted++;
      end
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      err_cnt++;
      if (err_cnt <= MAX_PRINTED) begin
         $display("%0t: response %0d %s mismatch: got 0x%0h, expected 0x%0h",
                  $realtime, checked_cnt, field, got, want);
      end
   endtask

   task automatic push_req(op_type op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata,
                           logic [REQ_SRC_W-1:0] src);
      plic_req_type r;
      r.op    = op;
      r.addr  = addr;
      r.wdata = wdata;
      r.src   = src;
      req_q.push_back(r);
   endtask

   // Random transaction: mostly well-formed register traffic and raises, some noise.
   function automatic plic_req_type random_req();
      plic_req_type r;
      int        pick;
      r.op    = OP_READ;
      r.addr  = ADDR_W'($urandom);
      r.wdata = $urandom;
      r.src   = REQ_SRC_W'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 28) begin
         r.op = OP_RAISE;
      end else if (pick < 43) begin
         r.addr = CLAIM_ADDR;
      end else if (pick < 53) begin
         r.op   = OP_WRITE;
         r.addr = CLAIM_ADDR;
         if ($urandom_range(0, 99) < 85) begin
            r.wdata = $urandom_range(0, NUM_SOURCES - 1);
         end
      end else if (pick < 65) begin
         r.op   = OP_WRITE;
         r.addr = ADDR_W'(4 * $urandom_range(0, NUM_SOURCES - 1));
         if ($urandom_range(0, 99) < 80) begin
            r.wdata = $urandom_range(0, MAX_PRIORITY);
         end
      end else if (pick < 71) begin
         r.addr = ADDR_W'(4 * $urandom_range(0, NUM_SOURCES - 1));
      end else if (pick < 76) begin
         r.op   = OP_WRITE;
         r.addr = ENABLE_BASE + ADDR_W'(4 * $urandom_range(0, BITMAP_WORDS - 1));
         if ($urandom_range(0, 1)) begin
            r.wdata = $urandom | $urandom;
         end
      end else if (pick < 80) begin
         r.addr = ($urandom_range(0, 1) ? ENABLE_BASE : PENDING_BASE)
                  + ADDR_W'(4 * $urandom_range(0, BITMAP_WORDS - 1));
      end else if (pick < 85) begin
         r.op   = $urandom_range(0, 2) != 0 ? OP_WRITE : OP_READ;
         r.addr = THRESHOLD_ADDR;
         if ($urandom_range(0, 99) < 85) begin
            r.wdata = $urandom_range(0, 3);
         end
      end else if (pick < 88) begin
         r.op   = OP_WRITE;
         r.addr = PENDING_BASE + ADDR_W'(4 * $urandom_range(0, BITMAP_WORDS - 1));
      end else if (pick < 96) begin
         // Noise: unaligned, out-of-range slot, or anywhere in the window.
         r.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
         case ($urandom_range(0, 2))
            0: begin
               r.addr[1:0] = 2'($urandom_range(1, 3));
            end
            1: begin
               r.addr = ADDR_W'(4 * $urandom_range(NUM_SOURCES, 1023));
            end
            default: begin
            end
         endcase
      end else begin
         r.op = OP_NONE;
      end
      return r;
   endfunction

   // Driver: a transaction is taken when start is high and busy is low.
   always @(posedge clock) begin : drive_req
      bit load;
      if (reset) begin
         start <= 1'b0;
      end else begin
         load = !start;
         if (start && !busy) begin
            due_rsp_q.push_back(compute_response(held_req));
            accepted_cnt++;
            load = 1'b1;
         end
         if (load) begin
            if (req_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               held_req = req_q.pop_front();
               start          <= 1'b1;
               req_operation  <= held_req.op;
               req_address    <= held_req.addr;
               req_write_data <= held_req.wdata;
               req_source     <= held_req.src;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe is compared with the oldest expected response.
   always @(posedge clock) begin : check_rsp
      plic_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_rsp_q.size() == 0) begin
            report_mismatch("unexpected response, read_data", rsp_read_data, '0);
         end else begin
            want = due_rsp_q.pop_front();
            if (rsp_read_data !== want.rdata) begin
               report_mismatch("read_data", rsp_read_data, want.rdata);
            end
            if (rsp_irq_request !== want.irq) begin
               report_mismatch("irq_request", DATA_W'(rsp_irq_request), DATA_W'(want.irq));
            end
            if (rsp_bad_access !== want.bad) begin
               report_mismatch("bad_access", DATA_W'(rsp_bad_access), DATA_W'(want.bad));
            end
            if (rsp_irq_request === 1'b1) begin
               irq_seen++;
            end
         end
         checked_cnt++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_cnt, due_rsp_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int idle_by_phase[4];
      idle_by_phase = '{0, 49, 0, 31};
      for (int s = 0; s < NUM_SOURCES; s++) begin
         shadow_prio[s] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = idle_by_phase[ph];
         if (ph == 0) begin
            // Directed opening: source zero, saturation, ties, read-only and bad decodes.
            push_req(OP_READ,  '0, '0, '0);
            push_req(OP_WRITE, '0, 32'd5, '0);
            push_req(OP_WRITE, ADDR_W'(4 * (NUM_SOURCES - 1)), '1, '0);
            push_req(OP_WRITE, ADDR_W'(4), 32'd7, '0);
            push_req(OP_WRITE, ADDR_W'(8), 32'd7, '0);
            push_req(OP_WRITE, ADDR_W'(20), 32'd3, '0);
            push_req(OP_WRITE, ENABLE_BASE, '1, '0);
            push_req(OP_WRITE, ENABLE_BASE + 26'd4, '1, '0);
            push_req(OP_READ,  ENABLE_BASE, '0, '0);
            push_req(OP_RAISE, '1, '1, 6'd0);
            push_req(OP_RAISE, '0, '0, 6'd2);
            push_req(OP_RAISE, '0, '0, 6'd1);
            push_req(OP_RAISE, '0, '0, 6'd63);
            push_req(OP_RAISE, '0, '0, 6'd5);
            push_req(OP_WRITE, PENDING_BASE, '0, '0);
            push_req(OP_READ,  PENDING_BASE + 26'd4, '0, '0);
            push_req(OP_WRITE, THRESHOLD_ADDR, '1, '0);
            push_req(OP_READ,  CLAIM_ADDR, '0, '0);
            push_req(OP_WRITE, THRESHOLD_ADDR, 32'd2, '0);
            push_req(OP_READ,  CLAIM_ADDR, '0, '0);
            push_req(OP_RAISE, '0, '0, 6'd1);
            push_req(OP_WRITE, CLAIM_ADDR, 32'd1, '0);
            push_req(OP_WRITE, CLAIM_ADDR, 32'd0, '0);
            push_req(OP_WRITE, CLAIM_ADDR, 32'd64, '0);
            push_req(OP_READ,  PENDING_BASE + 26'd1, '0, '0);
            push_req(OP_READ,  ADDR_W'(4 * NUM_SOURCES), '0, '0);
            push_req(OP_WRITE, PENDING_BASE + BITMAP_SPAN, '1, '0);
            push_req(OP_NONE,  '1, '1, '1);
            push_req(OP_READ,  THRESHOLD_ADDR, '0, '0);
         end
         for (int i = 0; i < RANDOM_PER_PH; i++) begin
            req_q.push_back(random_req());
         end
         // Hold the sender back until every response of this phase is in.
         while (req_q.size() != 0 || start || due_rsp_q.size() != 0) begin
            @(posedge clock);
         end
      end

      repeat (2 * RSP_LATENCY) @(posedge clock);
      $display("Checked %0d responses for %0d transactions: %0d claims granted, %0d bad decodes,",
               checked_cnt, accepted_cnt, claims_granted, bad_predicted);
      $display("%0d responses with an interrupt request, over four sender idle phases.",
               irq_seen);
      if (err_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
